// ===== hdl/frsc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frsc_pkg
// Shared types and constants of the frame receiver with additive checksum.
// ---------------------------------------------------------------------------
package frsc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'd90;
  localparam logic [BYTE_W-1:0] ID_LIMIT_RESET = 8'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT    = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IGNORED = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_ID      = 3'd2,
    KIND_LENGTH  = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_GOOD    = 3'd5,
    KIND_BAD     = 3'd6,
    KIND_REJECT  = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] pbyte;
    logic [BYTE_W-1:0] pidx;
    logic [BYTE_W-1:0] fid;
    logic [BYTE_W-1:0] flen;
  } result_t;

endpackage : frsc_pkg
`default_nettype wire

// ===== hdl/frame_receiver_sum_check_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frame_receiver_sum_check_core
// Byte-serial deframer for header, id, length, payload and 8-bit sum check.
// ---------------------------------------------------------------------------
// One received word in gives one result word out, one per clock cycle
// sustained while out_tready stays high; the result is registered in the
// result register that the per-byte state update feeds. A skid register
// behind the result register lets one more byte in while a result waits,
// so a stall on the output side drops in_tready only after two results are
// held. Configuration writes take effect from the next byte on.
// ---------------------------------------------------------------------------
module frame_receiver_sum_check_core
  import frsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [BYTE_W-1:0]     cfg_wr_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [4*BYTE_W-1:0]        out_tdata,  // [7:0] payload_byte, [15:8] payload_index,
                                                 // [23:16] frame_id, [31:24] frame_length
  output logic [KIND_W-1:0]          out_tuser   // [2:0] byte_kind
);

  logic [BYTE_W-1:0] header_r, limit_r;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] cnt_inc;
  logic [BYTE_W-1:0] sum_add;
  result_t           res;
  result_t           out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              acc, out_free;

  assign in_tready = !skid_valid_r;
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cnt_inc   = cnt_r + 8'd1;
  assign sum_add   = sum_r + in_tdata;

  // next state
  always_comb begin
    phase_nxt = PH_HUNT;
    case (phase_r)
      PH_ID:    phase_nxt = (in_tdata < limit_r) ? PH_LEN : PH_HUNT;
      PH_LEN:   phase_nxt = (in_tdata == '0) ? PH_CHECK : PH_DATA;
      PH_DATA:  phase_nxt = (cnt_inc >= len_r) ? PH_CHECK : PH_DATA;
      PH_CHECK: phase_nxt = PH_HUNT;
      default:  phase_nxt = (in_tdata == header_r) ? PH_ID : PH_HUNT;
    endcase
  end

  // result and datapath updates
  always_comb begin
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    res.kind  = KIND_IGNORED;
    res.pbyte = '0;
    res.pidx  = '0;
    res.fid   = '0;
    res.flen  = '0;
    case (phase_r)
      PH_ID: begin
        if (in_tdata < limit_r) begin
          id_nxt   = in_tdata;
          sum_nxt  = sum_add;
          res.kind = KIND_ID;
        end else begin
          res.kind = KIND_REJECT;
        end
        res.fid = in_tdata;
      end
      PH_LEN: begin
        len_nxt  = in_tdata;
        sum_nxt  = sum_add;
        res.kind = KIND_LENGTH;
        res.fid  = id_r;
        res.flen = in_tdata;
      end
      PH_DATA: begin
        cnt_nxt   = cnt_inc;
        sum_nxt   = sum_add;
        res.kind  = KIND_PAYLOAD;
        res.pbyte = in_tdata;
        res.pidx  = cnt_r;
        res.fid   = id_r;
        res.flen  = len_r;
      end
      PH_CHECK: begin
        res.kind = (sum_r == in_tdata) ? KIND_GOOD : KIND_BAD;
        res.fid  = id_r;
        res.flen = len_r;
      end
      default: begin
        if (in_tdata == header_r) begin
          id_nxt   = '0;
          len_nxt  = '0;
          cnt_nxt  = '0;
          sum_nxt  = in_tdata;
          res.kind = KIND_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      limit_r  <= ID_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER_BYTE: header_r <= cfg_wr_data;
        CFG_ID_LIMIT:    limit_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && acc) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.flen, out_r.fid, out_r.pidx, out_r.pbyte};
  assign out_tuser  = out_r.kind;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while output is empty");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !skid_valid_r) |=> out_valid_r)
    else $error("accepted word did not reach the output");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_PAYLOAD) |-> (out_r.pidx < out_r.flen))
    else $error("payload index beyond declared length");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < len_r))
    else $error("payload count reached length while still in payload");

endmodule : frame_receiver_sum_check_core
`default_nettype wire
